// ===== sv/nrmc_pkg.sv =====
// Types, character codes and helper functions shared by the RMC sentence checker.
package nrmc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;

    localparam logic [3:0] POS_NAME_FIRST = 4'd3;
    localparam logic [3:0] POS_NAME_MID   = 4'd4;
    localparam logic [3:0] POS_NAME_LAST  = 4'd5;
    localparam logic [3:0] POS_NAME_END   = 4'd6;
    localparam logic [3:0] POS_TIME       = 4'd7;
    localparam logic [3:0] POS_SAT        = 4'd8;

    typedef enum logic [2:0] {
        OUT_NOT_RMC   = 3'd0,
        OUT_SUM_ERR   = 3'd1,
        OUT_WAIT      = 3'd2,
        OUT_VALID     = 3'd3,
        OUT_NOT_VALID = 3'd4
    } t_outcome;

    typedef enum logic [1:0] {
        FIX_WAIT      = 2'd0,
        FIX_VALID     = 2'd1,
        FIX_NOT_VALID = 2'd2
    } t_fix;

    typedef enum logic [1:0] {
        SUM_BEFORE = 2'd0,
        SUM_FIRST  = 2'd1,
        SUM_SECOND = 2'd2
    } t_sum_phase;

    typedef enum logic [1:0] {
        FLD_BEFORE = 2'd0,
        FLD_TIME   = 2'd1,
        FLD_STATUS = 2'd2,
        FLD_DONE   = 2'd3
    } t_field_phase;

    typedef struct packed {
        logic       valid;
        t_outcome   outcome;
        t_fix       fix_status;
        logic [7:0] computed_sum;
    } t_result;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10) begin
            hex_digit = wide + 8'h30;
        end else begin
            hex_digit = wide + 8'h37;
        end
    endfunction

    function automatic logic [7:0] name_char(input logic [3:0] pos);
        case (pos)
            POS_NAME_FIRST: name_char = CH_R;
            POS_NAME_MID:   name_char = CH_M;
            POS_NAME_LAST:  name_char = CH_C;
            default:        name_char = 8'h00;
        endcase
    endfunction

endpackage

// ===== sv/nrmc_ifs.sv =====
// Valid/ready stream interfaces for received bytes and sentence results.
interface nrmc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface nrmc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] outcome;
    logic [1:0] fix_status;
    logic [7:0] computed_sum;

    modport source (output valid, output outcome, output fix_status, output computed_sum,
                    input ready);
    modport sink (input valid, input outcome, input fix_status, input computed_sum,
                  output ready);
endinterface

// ===== sv/nrmc_parser.sv =====
// Sentence state and per-byte parse logic: name check, XOR sum, field scan, outcome.
module nrmc_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output nrmc_pkg::t_result o_res
);

    logic                      r_in_sentence, n_in_sentence;
    logic [3:0]                r_pos, n_pos;
    logic                      r_name_ok, n_name_ok;
    logic [7:0]                r_xor, n_xor;
    nrmc_pkg::t_sum_phase      r_sum_phase, n_sum_phase;
    logic                      r_first_ok, n_first_ok;
    nrmc_pkg::t_field_phase    r_fld, n_fld;
    logic                      r_time_empty, n_time_empty;
    logic                      r_status_a, n_status_a;
    nrmc_pkg::t_fix            r_held, n_held;

    logic w_is_eol;
    logic w_name_done;

    always_comb begin
        n_in_sentence = r_in_sentence;
        n_pos         = r_pos;
        n_name_ok     = r_name_ok;
        n_xor         = r_xor;
        n_sum_phase   = r_sum_phase;
        n_first_ok    = r_first_ok;
        n_fld         = r_fld;
        n_time_empty  = r_time_empty;
        n_status_a    = r_status_a;
        n_held        = r_held;
        o_res         = '{valid: 1'b0, outcome: nrmc_pkg::OUT_NOT_RMC,
                          fix_status: r_held, computed_sum: r_xor};
        w_is_eol      = (i_byte == nrmc_pkg::CH_CR) || (i_byte == nrmc_pkg::CH_LF);
        w_name_done   = 1'b0;

        if (!i_step) begin
            o_res.valid = 1'b0;
        end else if (i_byte == nrmc_pkg::CH_DOLLAR) begin
            n_in_sentence = 1'b1;
            n_pos         = 4'd1;
            n_name_ok     = 1'b1;
            n_xor         = 8'h00;
            n_sum_phase   = nrmc_pkg::SUM_BEFORE;
            n_first_ok    = 1'b0;
            n_fld         = nrmc_pkg::FLD_BEFORE;
            n_time_empty  = 1'b0;
            n_status_a    = 1'b0;
        end else if (r_in_sentence) begin
            if (r_pos >= nrmc_pkg::POS_NAME_FIRST && r_pos <= nrmc_pkg::POS_NAME_LAST &&
                i_byte != nrmc_pkg::name_char(r_pos)) begin
                n_name_ok = 1'b0;
            end
            if (r_pos < nrmc_pkg::POS_SAT) begin
                n_pos = r_pos + 4'd1;
            end

            case (r_fld)
                nrmc_pkg::FLD_BEFORE: begin
                    if (r_pos == nrmc_pkg::POS_TIME) begin
                        if (i_byte == nrmc_pkg::CH_COMMA) begin
                            n_time_empty = 1'b1;
                            n_fld        = nrmc_pkg::FLD_DONE;
                        end else begin
                            n_fld = nrmc_pkg::FLD_TIME;
                        end
                    end
                end
                nrmc_pkg::FLD_TIME: begin
                    if (i_byte == nrmc_pkg::CH_COMMA) begin
                        n_fld = nrmc_pkg::FLD_STATUS;
                    end
                end
                nrmc_pkg::FLD_STATUS: begin
                    n_status_a = (i_byte == nrmc_pkg::CH_A);
                    n_fld      = nrmc_pkg::FLD_DONE;
                end
                default: begin
                    n_fld = r_fld;
                end
            endcase

            w_name_done = n_name_ok && (n_pos >= nrmc_pkg::POS_NAME_END);

            if (w_is_eol) begin
                n_in_sentence = 1'b0;
                o_res.valid   = 1'b1;
                o_res.outcome = w_name_done ? nrmc_pkg::OUT_SUM_ERR : nrmc_pkg::OUT_NOT_RMC;
            end else begin
                case (r_sum_phase)
                    nrmc_pkg::SUM_BEFORE: begin
                        if (i_byte == nrmc_pkg::CH_STAR) begin
                            n_sum_phase = nrmc_pkg::SUM_FIRST;
                        end else begin
                            n_xor = r_xor ^ i_byte;
                        end
                    end
                    nrmc_pkg::SUM_FIRST: begin
                        n_first_ok  = (i_byte == nrmc_pkg::hex_digit(r_xor[7:4]));
                        n_sum_phase = nrmc_pkg::SUM_SECOND;
                    end
                    default: begin
                        n_in_sentence = 1'b0;
                        o_res.valid   = 1'b1;
                        if (!w_name_done) begin
                            o_res.outcome = nrmc_pkg::OUT_NOT_RMC;
                        end else if (!(r_first_ok &&
                                       i_byte == nrmc_pkg::hex_digit(r_xor[3:0]))) begin
                            o_res.outcome = nrmc_pkg::OUT_SUM_ERR;
                        end else if (n_time_empty) begin
                            o_res.outcome = nrmc_pkg::OUT_WAIT;
                            n_held        = nrmc_pkg::FIX_WAIT;
                        end else if (n_status_a) begin
                            o_res.outcome = nrmc_pkg::OUT_VALID;
                            n_held        = nrmc_pkg::FIX_VALID;
                        end else begin
                            o_res.outcome = nrmc_pkg::OUT_NOT_VALID;
                            n_held        = nrmc_pkg::FIX_NOT_VALID;
                        end
                        o_res.fix_status = n_held;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence <= 1'b0;
            r_pos         <= 4'd0;
            r_name_ok     <= 1'b1;
            r_xor         <= 8'h00;
            r_sum_phase   <= nrmc_pkg::SUM_BEFORE;
            r_first_ok    <= 1'b0;
            r_fld         <= nrmc_pkg::FLD_BEFORE;
            r_time_empty  <= 1'b0;
            r_status_a    <= 1'b0;
            r_held        <= nrmc_pkg::FIX_WAIT;
        end else begin
            r_in_sentence <= n_in_sentence;
            r_pos         <= n_pos;
            r_name_ok     <= n_name_ok;
            r_xor         <= n_xor;
            r_sum_phase   <= n_sum_phase;
            r_first_ok    <= n_first_ok;
            r_fld         <= n_fld;
            r_time_empty  <= n_time_empty;
            r_status_a    <= n_status_a;
            r_held        <= n_held;
        end
    end

endmodule

// ===== sv/nmea_rmc_sentence_checker.sv =====
// Top level of the NMEA RMC sentence checker: input register, parser, result register.
// Accepts one received byte per cycle on i_rx and reports each finished '$' sentence on
// o_res: outcome (not RMC, checksum error, wait, valid, not valid), the held fix status
// and the XOR sum of the bytes between '$' and '*'. The byte that ends the sentence
// (the second checksum digit, or CR/LF) passes through the input register and then
// the result register before its result appears. The parser consumes one byte per
// cycle while the result register is empty or being drained, so throughput is one byte
// per clock; a stalled result holds the byte pipeline whether or not the next byte ends
// a sentence, and with the input register also full the input stalls.
module nmea_rmc_sentence_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nrmc_byte_if.sink     i_rx,
    nrmc_result_if.source o_res
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    nrmc_pkg::t_result r_out;
    logic              w_adv;
    nrmc_pkg::t_result w_res;

    assign w_adv      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    nrmc_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res.valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.valid) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.outcome      = r_out.outcome;
    assign o_res.fix_status   = r_out.fix_status;
    assign o_res.computed_sum = r_out.computed_sum;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the NMEA RMC sentence checker: random and directed sentences, self-checking.
module tb;

    typedef struct {
        nrmc_pkg::t_outcome outcome;
        nrmc_pkg::t_fix     fix;
        logic [7:0]         sum;
    } t_rmc_result;

    typedef enum int {
        TAIL_GOOD,
        TAIL_BAD,
        TAIL_LOWER,
        TAIL_HALF_CR,
        TAIL_CR,
        TAIL_LF,
        TAIL_NONE
    } t_tail;

    class rmc_scoreboard;
        bit                     in_sentence;
        logic [3:0]             position;
        bit                     name_good;
        logic [7:0]             xor_acc;
        nrmc_pkg::t_sum_phase   sum_phase;
        bit                     first_digit_ok;
        nrmc_pkg::t_field_phase field_phase;
        bit                     time_empty;
        bit                     status_a;
        nrmc_pkg::t_fix         held;
        t_rmc_result            expected_q[$];
        int                     errors;

        function new();
            open_sentence();
            in_sentence = 0;
            position    = 4'd0;
            held        = nrmc_pkg::FIX_WAIT;
            errors      = 0;
        endfunction

        static function logic [7:0] upper_hex(input logic [3:0] nib);
            return (nib < 4'd10) ? 8'h30 + nib : 8'h37 + nib;
        endfunction

        function void open_sentence();
            in_sentence    = 1;
            position       = 4'd1;
            name_good      = 1;
            xor_acc        = 8'h00;
            sum_phase      = nrmc_pkg::SUM_BEFORE;
            first_digit_ok = 0;
            field_phase    = nrmc_pkg::FLD_BEFORE;
            time_empty     = 0;
            status_a       = 0;
        endfunction

        function void note_byte(input logic [7:0] b);
            logic [3:0]         p;
            bit                 name_ok;
            nrmc_pkg::t_outcome o;
            if (b == nrmc_pkg::CH_DOLLAR) begin
                open_sentence();
                return;
            end
            if (!in_sentence) return;

            p = position;
            case (p)
                nrmc_pkg::POS_NAME_FIRST: if (b != nrmc_pkg::CH_R) name_good = 0;
                nrmc_pkg::POS_NAME_MID:   if (b != nrmc_pkg::CH_M) name_good = 0;
                nrmc_pkg::POS_NAME_LAST:  if (b != nrmc_pkg::CH_C) name_good = 0;
                default: ;
            endcase
            if (p < nrmc_pkg::POS_SAT) position = p + 4'd1;

            case (field_phase)
                nrmc_pkg::FLD_BEFORE: begin
                    if (p == nrmc_pkg::POS_TIME) begin
                        if (b == nrmc_pkg::CH_COMMA) begin
                            time_empty  = 1;
                            field_phase = nrmc_pkg::FLD_DONE;
                        end else begin
                            field_phase = nrmc_pkg::FLD_TIME;
                        end
                    end
                end
                nrmc_pkg::FLD_TIME: begin
                    if (b == nrmc_pkg::CH_COMMA) field_phase = nrmc_pkg::FLD_STATUS;
                end
                nrmc_pkg::FLD_STATUS: begin
                    status_a    = (b == nrmc_pkg::CH_A);
                    field_phase = nrmc_pkg::FLD_DONE;
                end
                default: ;
            endcase

            name_ok = name_good && (position >= nrmc_pkg::POS_NAME_END);

            if (b == nrmc_pkg::CH_CR || b == nrmc_pkg::CH_LF) begin
                in_sentence = 0;
                o = name_ok ? nrmc_pkg::OUT_SUM_ERR : nrmc_pkg::OUT_NOT_RMC;
                expected_q.push_back('{o, held, xor_acc});
                return;
            end

            case (sum_phase)
                nrmc_pkg::SUM_BEFORE: begin
                    if (b == nrmc_pkg::CH_STAR) sum_phase = nrmc_pkg::SUM_FIRST;
                    else xor_acc ^= b;
                end
                nrmc_pkg::SUM_FIRST: begin
                    first_digit_ok = (b == upper_hex(xor_acc[7:4]));
                    sum_phase      = nrmc_pkg::SUM_SECOND;
                end
                default: begin
                    in_sentence = 0;
                    if (!name_ok) begin
                        o = nrmc_pkg::OUT_NOT_RMC;
                    end else if (!(first_digit_ok && b == upper_hex(xor_acc[3:0]))) begin
                        o = nrmc_pkg::OUT_SUM_ERR;
                    end else if (time_empty) begin
                        o    = nrmc_pkg::OUT_WAIT;
                        held = nrmc_pkg::FIX_WAIT;
                    end else if (status_a) begin
                        o    = nrmc_pkg::OUT_VALID;
                        held = nrmc_pkg::FIX_VALID;
                    end else begin
                        o    = nrmc_pkg::OUT_NOT_VALID;
                        held = nrmc_pkg::FIX_NOT_VALID;
                    end
                    expected_q.push_back('{o, held, xor_acc});
                end
            endcase
        endfunction

        function void check_result(input logic [2:0] o, input logic [1:0] f,
                                   input logic [7:0] s);
            t_rmc_result e;
            bit          bad;
            if (expected_q.size() == 0) begin
                if (errors < 10)
                    $display("%0t: unexpected result %0d/%0d/%02h", $time, o, f, s);
                errors++;
                return;
            end
            e   = expected_q.pop_front();
            bad = 0;
            if (o !== e.outcome) bad = 1;
            if (f !== e.fix) bad = 1;
            if (s !== e.sum) bad = 1;
            if (bad) begin
                if (errors < 10)
                    $display("%0t: mismatch expected %0d/%0d/%02h got %0d/%0d/%02h", $time,
                             e.outcome, e.fix, e.sum, o, f, s);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    nrmc_byte_if   rx_if ();
    nrmc_result_if res_if ();

    nmea_rmc_sentence_checker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    rmc_scoreboard sb;
    int            src_idle_pct;
    int            sink_idle_pct;
    bit            hold_req;
    int            bytes_sent;
    logic [7:0]    body_q[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic load_body(input string s);
        body_q.delete();
        for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
    endtask

    task automatic send_sentence(input t_tail tail);
        logic [7:0] sum;
        logic [7:0] hi;
        logic [7:0] lo;
        sum = 8'h00;
        foreach (body_q[i]) sum ^= body_q[i];
        push_byte(nrmc_pkg::CH_DOLLAR);
        foreach (body_q[i]) push_byte(body_q[i]);
        if (tail == TAIL_BAD) sum ^= 8'($urandom_range(1, 255));
        hi = rmc_scoreboard::upper_hex(sum[7:4]);
        lo = rmc_scoreboard::upper_hex(sum[3:0]);
        if (tail == TAIL_LOWER) begin
            if (hi >= nrmc_pkg::CH_A) hi |= 8'h20;
            if (lo >= nrmc_pkg::CH_A) lo |= 8'h20;
        end
        case (tail)
            TAIL_GOOD, TAIL_BAD, TAIL_LOWER: begin
                push_byte(nrmc_pkg::CH_STAR);
                push_byte(hi);
                push_byte(lo);
            end
            TAIL_HALF_CR: begin
                push_byte(nrmc_pkg::CH_STAR);
                push_byte(hi);
                push_byte(nrmc_pkg::CH_CR);
            end
            TAIL_CR: push_byte(nrmc_pkg::CH_CR);
            TAIL_LF: push_byte(nrmc_pkg::CH_LF);
            default: ;
        endcase
    endtask

    function automatic logic [7:0] rand_text_char();
        logic [7:0] c;
        if ($urandom_range(99) < 8) return 8'($urandom_range(128, 255));
        do c = 8'($urandom_range(32, 126));
        while (c == nrmc_pkg::CH_DOLLAR || c == nrmc_pkg::CH_STAR);
        return c;
    endfunction

    task automatic rand_sentence();
        int    r;
        int    n;
        t_tail tail;
        r = $urandom_range(99);
        if (r < 10) begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
            return;
        end
        body_q.delete();
        if (r < 15) begin
            repeat ($urandom_range(0, 12)) body_q.push_back(8'($urandom_range(255)));
            send_sentence(TAIL_GOOD);
            return;
        end
        if (r < 20) begin
            push_byte(nrmc_pkg::CH_DOLLAR);
            repeat ($urandom_range(0, 4)) push_byte(rand_text_char());
        end
        repeat (2) body_q.push_back(8'($urandom_range(65, 90)));
        if ($urandom_range(99) < 85) begin
            body_q.push_back(nrmc_pkg::CH_R);
            body_q.push_back(nrmc_pkg::CH_M);
            body_q.push_back(nrmc_pkg::CH_C);
        end else begin
            repeat (3) body_q.push_back(8'($urandom_range(65, 90)));
        end
        body_q.push_back(nrmc_pkg::CH_COMMA);
        if ($urandom_range(99) >= 30) begin
            repeat ($urandom_range(1, 6))
                body_q.push_back(($urandom_range(99) < 90) ? 8'($urandom_range(48, 57))
                                                            : rand_text_char());
        end
        if ($urandom_range(99) < 85) begin
            body_q.push_back(nrmc_pkg::CH_COMMA);
            r = $urandom_range(99);
            if (r < 45) body_q.push_back(nrmc_pkg::CH_A);
            else if (r < 80) body_q.push_back("V");
            else if (r < 90) body_q.push_back(nrmc_pkg::CH_COMMA);
            else body_q.push_back(rand_text_char());
        end
        repeat ($urandom_range(0, 3)) begin
            body_q.push_back(nrmc_pkg::CH_COMMA);
            repeat ($urandom_range(0, 3)) body_q.push_back(rand_text_char());
        end
        r = $urandom_range(99);
        if (r < 72) begin
            tail = TAIL_GOOD;
        end else if (r < 80) begin
            tail = TAIL_BAD;
        end else if (r < 84) begin
            tail = TAIL_LOWER;
        end else if (r < 88) begin
            tail = TAIL_HALF_CR;
        end else begin
            n = $urandom_range(0, body_q.size());
            while (body_q.size() > n) void'(body_q.pop_back());
            if (r < 94) tail = TAIL_CR;
            else tail = TAIL_LF;
        end
        send_sentence(tail);
        if ($urandom_range(1)) begin
            push_byte(nrmc_pkg::CH_CR);
            push_byte(nrmc_pkg::CH_LF);
        end
    endtask

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_left = 400;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else begin
                res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
            @(posedge i_clk);
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.outcome, res_if.fix_status, res_if.computed_sum);
        end
    end

    initial begin : byte_source
        int target;
        sb = new();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_req      = 0;
        bytes_sent    = 0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        i_rst_n       <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 12;
        sink_idle_pct = 78;
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(nrmc_pkg::CH_LF);
        load_body("GPRMC,1,A"); send_sentence(TAIL_GOOD);
        load_body("GPRMC,1,V"); send_sentence(TAIL_GOOD);
        load_body("GPRMC,,V");  send_sentence(TAIL_GOOD);
        load_body("GPRMC,1");   send_sentence(TAIL_GOOD);
        load_body("GPRMC,1,A"); send_sentence(TAIL_BAD);
        load_body("GPRMC,1,A"); send_sentence(TAIL_LOWER);
        load_body("GPGGA,1");   send_sentence(TAIL_BAD);
        load_body("GP");        send_sentence(TAIL_CR);
        load_body("GPRMC,1");   send_sentence(TAIL_LF);
        load_body("GPRMC,1,A"); send_sentence(TAIL_HALF_CR);
        load_body("GP");        send_sentence(TAIL_GOOD);
        load_body("GPR");       send_sentence(TAIL_NONE);
        load_body("GPRMC,,A");  send_sentence(TAIL_GOOD);
        load_body("GPRMC,1,A,");
        body_q.push_back(8'hFF);
        body_q.push_back(8'h80);
        send_sentence(TAIL_GOOD);

        target = bytes_sent + 310;
        while (bytes_sent < target) rand_sentence();

        src_idle_pct  = 78;
        sink_idle_pct = 12;
        target = bytes_sent + 310;
        while (bytes_sent < target) rand_sentence();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_req      = 1;
        target = bytes_sent + 310;
        while (bytes_sent < target) rand_sentence();
        rx_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/nrmc_pkg.sv
sv/nrmc_ifs.sv
sv/nrmc_parser.sv
sv/nmea_rmc_sentence_checker.sv
sim/tb.sv
